// ----- rtl/core/fpfa_pkg.sv -----
// fpfa_pkg: shared constants and types of the fixed partition fit allocator
`default_nettype none

package fpfa_pkg;

    localparam int DEF_MAX_SLOTS = 64;
    localparam int DEF_SIZE_BITS = 16;

    localparam int CMD_W     = 1;
    localparam int POL_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int SIZEV_W   = 16;
    localparam int OUT_IDX_W = 6;
    localparam int PIN_W     = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd2;
    localparam logic [POL_W-1:0] POL_WORST = 2'd3;

    localparam logic REG_PARTITIONS_IN_USE = 1'b0;
    localparam logic [PIN_W-1:0] PIN_RESET = 7'd1;

    localparam int FLAG_W          = 2;
    localparam int FLAG_LOADED_BIT = 1;
    localparam int FLAG_TAKEN_BIT  = 0;
    localparam logic [FLAG_W-1:0] FLAGS_EMPTY  = 2'b00;
    localparam logic [FLAG_W-1:0] FLAGS_LOADED = 2'b10;
    localparam logic [FLAG_W-1:0] FLAGS_TAKEN  = 2'b11;

    typedef struct packed {
        logic             start;
        logic [POL_W-1:0] policy;
    } scan_ctl_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/fpfa_ram.sv -----
// fpfa_ram: generic single write port, single read port ram with registered read
`default_nettype none

module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fpfa_scan.sv -----
// fpfa_scan: linear table scan that picks a partition under the four fit policies
`default_nettype none

module fpfa_scan import fpfa_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int IDX_W     = $clog2(MAX_SLOTS),
    parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire  scan_ctl_t   ctl,
    input  wire  [SIZE_BITS-1:0] req_size,
    input  wire  [CNT_W-1:0]  count,
    input  wire  [IDX_W-1:0]  rover,
    output logic [IDX_W-1:0]  rd_addr,
    input  wire  [SIZE_BITS-1:0] rd_size,
    input  wire  [FLAG_W-1:0] rd_flags,
    output scan_sts_t         sts,
    output logic [IDX_W-1:0]  pick
);

    logic                 issue_reg, issue_next;
    logic                 chk_reg, chk_next;
    logic                 chk_last_reg, chk_last_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [POL_W-1:0]     policy_reg, policy_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [IDX_W-1:0]     rover_reg, rover_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic                 ge_hit_reg, ge_hit_next;
    logic [IDX_W-1:0]     ge_idx_reg, ge_idx_next;

    logic [CNT_W-1:0] cnt_inc;
    logic             fits;
    logic             take;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign rd_addr = cnt_reg[IDX_W-1:0];
    assign fits    = rd_flags[FLAG_LOADED_BIT] && !rd_flags[FLAG_TAKEN_BIT]
                     && (rd_size >= req_reg);

    always_comb begin
        unique case (policy_reg)
            POL_BEST:  take = !hit_reg || (rd_size < pick_size_reg);
            POL_WORST: take = !hit_reg || (rd_size > pick_size_reg);
            default:   take = !hit_reg;
        endcase
    end

    always_comb begin
        issue_next     = issue_reg;
        chk_next       = 1'b0;
        chk_last_next  = 1'b0;
        done_next      = 1'b0;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        chk_idx_next   = chk_idx_reg;
        policy_next    = policy_reg;
        req_next       = req_reg;
        rover_next     = rover_reg;
        hit_next       = hit_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        ge_hit_next    = ge_hit_reg;
        ge_idx_next    = ge_idx_reg;
        if (ctl.start) begin
            policy_next = ctl.policy;
            req_next    = req_size;
            rover_next  = rover;
            count_next  = count;
            cnt_next    = '0;
            issue_next  = (count != '0);
            done_next   = (count == '0);
            hit_next    = 1'b0;
            ge_hit_next = 1'b0;
        end else begin
            done_next     = chk_reg && chk_last_reg;
            chk_next      = issue_reg;
            chk_last_next = issue_reg && (cnt_inc == count_reg);
            chk_idx_next  = cnt_reg[IDX_W-1:0];
            if (issue_reg) begin
                cnt_next = cnt_inc;
                if (cnt_inc == count_reg) begin
                    issue_next = 1'b0;
                end
            end
            if (chk_reg && fits) begin
                if (take) begin
                    hit_next       = 1'b1;
                    pick_next      = chk_idx_reg;
                    pick_size_next = rd_size;
                end
                if (!ge_hit_reg && (chk_idx_reg >= rover_reg)) begin
                    ge_hit_next = 1'b1;
                    ge_idx_next = chk_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg    <= 1'b0;
            chk_reg      <= 1'b0;
            chk_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            issue_reg    <= issue_next;
            chk_reg      <= chk_next;
            chk_last_reg <= chk_last_next;
            done_reg     <= done_next;
        end
        cnt_reg       <= cnt_next;
        count_reg     <= count_next;
        chk_idx_reg   <= chk_idx_next;
        policy_reg    <= policy_next;
        req_reg       <= req_next;
        rover_reg     <= rover_next;
        hit_reg       <= hit_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        ge_hit_reg    <= ge_hit_next;
        ge_idx_reg    <= ge_idx_next;
    end

    // next fit prefers the first hit at or above the rover, else wraps to the first hit
    always_comb begin
        sts.done = done_reg;
        if ((policy_reg == POL_NEXT) && ge_hit_reg) begin
            sts.found = 1'b1;
            pick      = ge_idx_reg;
        end else begin
            sts.found = hit_reg;
            pick      = pick_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fixed_partition_fit_allocator.sv -----
// fixed_partition_fit_allocator: top level of the fixed partition fit allocator
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_cmd, s_policy, s_slot_index, s_size_value
//   m_        out        m_valid / m_ready  m_granted, m_granted_index
//   apb       in         psel / penable     paddr, pwdata, prdata (partitions_in_use)
//
// a load request writes the size and flag rams and passes through ST_DONE to the result;
// an allocate request runs a one-read-per-cycle scan of the size and flag rams over the
// active partition count, then marks the pick taken and registers the result in ST_DONE
// after reset a clearing pass over all MAX_SLOTS entries resets the flag ram; s_ready stays low
// a new request is taken while a finished result waits on m_; the next result holds
// until the output register is free
`default_nettype none

module fixed_partition_fit_allocator import fpfa_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  [CMD_W-1:0]       s_cmd,
    input  wire  [POL_W-1:0]       s_policy,
    input  wire  [SLOT_W-1:0]      s_slot_index,
    input  wire  [SIZEV_W-1:0]     s_size_value,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic                   m_granted,
    output logic [OUT_IDX_W-1:0]   m_granted_index,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [APB_ADDR_W-1:0]  paddr,
    input  wire  [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [PIN_W-1:0]     pin_reg, pin_next;
    logic [IDX_W-1:0]     rover_reg, rover_next;
    logic [POL_W-1:0]     pol_reg, pol_next;
    logic                 res_granted_reg, res_granted_next;
    logic [OUT_IDX_W-1:0] res_index_reg, res_index_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_granted_reg, m_granted_next;
    logic [OUT_IDX_W-1:0] m_index_reg, m_index_next;

    logic                 s_acc;
    logic                 slot_ok;
    logic [IDX_W-1:0]     slot_addr;
    logic [SIZE_BITS-1:0] req_size;
    logic [CNT_W-1:0]     active_n;
    logic                 size_we;
    logic                 flag_we;
    logic [IDX_W-1:0]     flag_waddr;
    logic [FLAG_W-1:0]    flag_wdata;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_size;
    logic [FLAG_W-1:0]    rd_flags;
    logic [IDX_W-1:0]     pick;
    scan_ctl_t            scan_ctl;
    scan_sts_t            scan_sts;
    logic                 cfg_wr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign slot_ok   = (32'(s_slot_index) < MAX_SLOTS);
    assign slot_addr = IDX_W'(s_slot_index);
    assign req_size  = SIZE_BITS'(s_size_value);
    assign active_n  = (32'(pin_reg) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(pin_reg);
    assign size_we   = s_acc && (s_cmd == CMD_LOAD) && slot_ok;

    assign scan_ctl.start  = s_acc && (s_cmd == CMD_ALLOC);
    assign scan_ctl.policy = s_policy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PARTITIONS_IN_USE);
    assign prdata = (paddr[2] == REG_PARTITIONS_IN_USE) ? APB_DATA_W'(pin_reg) : '0;

    always_comb begin
        flag_we    = 1'b0;
        flag_waddr = slot_addr;
        flag_wdata = FLAGS_LOADED;
        unique case (state_reg)
            ST_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = clr_cnt_reg;
                flag_wdata = FLAGS_EMPTY;
            end
            ST_IDLE: begin
                flag_we = size_we;
            end
            ST_SCAN: begin
                flag_we    = scan_sts.done && scan_sts.found;
                flag_waddr = pick;
                flag_wdata = FLAGS_TAKEN;
            end
            default: begin
                flag_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        pin_next         = pin_reg;
        rover_next       = rover_reg;
        pol_next         = pol_reg;
        res_granted_next = res_granted_reg;
        res_index_next   = res_index_reg;
        m_valid_next     = m_valid_reg;
        m_granted_next   = m_granted_reg;
        m_index_next     = m_index_reg;
        if (cfg_wr) begin
            pin_next = pwdata[PIN_W-1:0];
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(MAX_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    pol_next         = s_policy;
                    res_granted_next = 1'b0;
                    res_index_next   = '0;
                    state_next       = (s_cmd == CMD_LOAD) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_sts.done) begin
                    res_granted_next = scan_sts.found;
                    res_index_next   = scan_sts.found ? OUT_IDX_W'(pick) : '0;
                    if (scan_sts.found && (pol_reg == POL_NEXT)) begin
                        rover_next = pick;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_index_next   = res_index_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pin_reg     <= PIN_RESET;
            rover_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pin_reg     <= pin_next;
            rover_reg   <= rover_next;
            m_valid_reg <= m_valid_next;
        end
        pol_reg         <= pol_next;
        res_granted_reg <= res_granted_next;
        res_index_reg   <= res_index_next;
        m_granted_reg   <= m_granted_next;
        m_index_reg     <= m_index_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_granted       = m_granted_reg;
    assign m_granted_index = m_index_reg;

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_size_ram (
        .aclk    (aclk),
        .wr_en   (size_we),
        .wr_addr (slot_addr),
        .wr_data (req_size),
        .rd_addr (rd_addr),
        .rd_data (rd_size)
    );

    fpfa_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_SLOTS)
    ) u_flag_ram (
        .aclk    (aclk),
        .wr_en   (flag_we),
        .wr_addr (flag_waddr),
        .wr_data (flag_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_flags)
    );

    fpfa_scan #(
        .MAX_SLOTS (MAX_SLOTS),
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .req_size (req_size),
        .count    (active_n),
        .rover    (rover_reg),
        .rd_addr  (rd_addr),
        .rd_size  (rd_size),
        .rd_flags (rd_flags),
        .sts      (scan_sts),
        .pick     (pick)
    );

endmodule

`default_nettype wire

// ----- verif/fixed_partition_fit_allocator_tb.sv -----
// fixed_partition_fit_allocator_tb: self-checking testbench for the partition fit allocator
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_tb import fpfa_pkg::*;;

    localparam int NUM_SLOTS      = DEF_MAX_SLOTS;
    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_TAIL     = NUM_SLOTS + 8;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 72;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POL_W-1:0]   policy;
        logic [SLOT_W-1:0]  slot;
        logic [SIZEV_W-1:0] size;
    } alloc_req_t;

    typedef struct packed {
        logic                 granted;
        logic [OUT_IDX_W-1:0] index;
    } grant_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    wire                   s_ready;
    logic [CMD_W-1:0]      s_cmd = '0;
    logic [POL_W-1:0]      s_policy = '0;
    logic [SLOT_W-1:0]     s_slot_index = '0;
    logic [SIZEV_W-1:0]    s_size_value = '0;
    wire                   m_valid;
    logic                  m_ready = 1'b0;
    wire                   m_granted;
    wire [OUT_IDX_W-1:0]   m_granted_index;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    wire [APB_DATA_W-1:0]  prdata;
    wire                   pready;

    fixed_partition_fit_allocator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_policy        (s_policy),
        .s_slot_index    (s_slot_index),
        .s_size_value    (s_size_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_granted_index (m_granted_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 aclk = ~aclk;

    // predicted allocator state
    logic [SIZEV_W-1:0] size_tab [NUM_SLOTS];
    bit                 loaded_tab [NUM_SLOTS];
    bit                 taken_tab [NUM_SLOTS];
    int                 rover_idx = 0;
    logic [PIN_W-1:0]   slots_active = PIN_RESET;

    alloc_req_t pending_reqs [$];
    grant_t     expected_grants [$];
    alloc_req_t inflight_req;

    int  pushed_total = 0;
    int  results_seen = 0;
    int  errors = 0;
    int  loads_sent = 0;
    int  allocs_sent = 0;
    int  grants_seen = 0;
    int  count_writes = 0;
    int  stall_asks = 0;
    int  stall_taken = 0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    int  rx_hold = 0;
    int  quiet_cycles = 0;
    bit  idle_enable = 1'b1;

    function automatic bit slot_fits(int i, logic [SIZEV_W-1:0] want);
        return loaded_tab[i] && !taken_tab[i] && size_tab[i] >= want;
    endfunction

    function automatic grant_t predict_grant(alloc_req_t r);
        grant_t g;
        int     n;
        int     pick;
        int     i;
        g.granted = 1'b0;
        g.index = '0;
        if (r.cmd == CMD_LOAD) begin
            size_tab[r.slot] = r.size;
            loaded_tab[r.slot] = 1'b1;
            taken_tab[r.slot] = 1'b0;
            return g;
        end
        n = (slots_active > NUM_SLOTS) ? NUM_SLOTS : int'(slots_active);
        pick = -1;
        case (r.policy)
            POL_FIRST: begin
                for (i = 0; i < n; i++)
                    if (pick < 0 && slot_fits(i, r.size)) pick = i;
            end
            POL_BEST: begin
                for (i = 0; i < n; i++)
                    if (slot_fits(i, r.size) && (pick < 0 || size_tab[i] < size_tab[pick]))
                        pick = i;
            end
            POL_WORST: begin
                for (i = 0; i < n; i++)
                    if (slot_fits(i, r.size) && (pick < 0 || size_tab[i] > size_tab[pick]))
                        pick = i;
            end
            POL_NEXT: begin
                for (i = rover_idx; i < n; i++)
                    if (pick < 0 && slot_fits(i, r.size)) pick = i;
                for (i = 0; i < ((rover_idx < n) ? rover_idx : n); i++)
                    if (pick < 0 && slot_fits(i, r.size)) pick = i;
                if (pick >= 0) rover_idx = pick;
            end
        endcase
        if (pick >= 0) begin
            taken_tab[pick] = 1'b1;
            g.granted = 1'b1;
            g.index = OUT_IDX_W'(pick);
        end
        return g;
    endfunction

    function automatic alloc_req_t random_req();
        alloc_req_t r;
        int         pick;
        r.cmd = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_ALLOC;
        r.policy = POL_W'($urandom_range(0, 3));
        r.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0) r.size = '0;
        else if (pick == 1) r.size = '1;
        else r.size = SIZEV_W'($urandom_range(0, 16'hFFFF));
        return r;
    endfunction

    task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [POL_W-1:0] policy,
                            input int slot, input logic [SIZEV_W-1:0] size);
        alloc_req_t r;
        r.cmd = cmd;
        r.policy = policy;
        r.slot = SLOT_W'(slot);
        r.size = size;
        pending_reqs.push_back(r);
        pushed_total++;
    endtask

    task automatic wait_drained();
        while (results_seen != pushed_total) @(posedge aclk);
    endtask

    task automatic write_count(input logic [PIN_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * REG_PARTITIONS_IN_USE);
        pwdata <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        slots_active = value;
        count_writes++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_grants.push_back(predict_grant(inflight_req));
                if (inflight_req.cmd == CMD_LOAD) loads_sent++;
                else allocs_sent++;
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                inflight_req = pending_reqs.pop_front();
                s_cmd <= inflight_req.cmd;
                s_policy <= inflight_req.policy;
                s_slot_index <= inflight_req.slot;
                s_size_value <= inflight_req.size;
                s_valid <= 1'b1;
                tx_gap <= idle_enable ? $urandom_range(0, 3) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver
    always @(posedge aclk) begin
        grant_t want;
        int     w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_granted) grants_seen++;
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual granted %0d index %0d",
                             $time, m_granted, m_granted_index);
                    errors++;
                end else begin
                    want = expected_grants.pop_front();
                    if (m_granted !== want.granted) begin
                        $display("%0t: granted mismatch, expected %0d actual %0d",
                                 $time, want.granted, m_granted);
                        errors++;
                    end
                    if (m_granted_index !== want.index) begin
                        $display("%0t: granted_index mismatch, expected %0d actual %0d",
                                 $time, want.index, m_granted_index);
                        errors++;
                    end
                end
            end
            if (stall_asks != stall_taken) begin
                stall_taken = stall_asks;
                rx_hold = LONG_STALL;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                w = idle_enable ? $urandom_range(0, 3) : 0;
                rx_wait = w;
                m_ready <= (w == 0);
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_ready <= (rx_wait == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        logic [PIN_W-1:0] cnt;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // single active slot after reset
        push_req(CMD_LOAD, POL_FIRST, 0, 16'd100);
        push_req(CMD_ALLOC, POL_FIRST, 0, 16'd0);
        push_req(CMD_ALLOC, POL_FIRST, 0, 16'd0);
        push_req(CMD_LOAD, POL_WORST, 0, 16'hFFFF);
        push_req(CMD_ALLOC, POL_BEST, 0, 16'hFFFF);
        push_req(CMD_LOAD, POL_NEXT, 0, 16'd0);
        push_req(CMD_ALLOC, POL_WORST, 0, 16'd1);
        push_req(CMD_ALLOC, POL_NEXT, 0, 16'd0);

        // zero active slots: every allocate misses
        write_count(7'd0);
        push_req(CMD_LOAD, POL_FIRST, 0, 16'd5);
        push_req(CMD_ALLOC, POL_FIRST, 63, 16'd0);
        push_req(CMD_ALLOC, POL_BEST, 63, 16'd0);
        push_req(CMD_ALLOC, POL_NEXT, 63, 16'd0);
        push_req(CMD_ALLOC, POL_WORST, 63, 16'd0);

        // load the whole table before wider scans
        write_count(PIN_RESET);
        for (k = 0; k < NUM_SLOTS; k++)
            push_req(CMD_LOAD, POL_W'($urandom_range(0, 3)), k,
                     SIZEV_W'($urandom_range(1, 16'hFFFE)));

        write_count(7'd64);
        push_req(CMD_LOAD, POL_FIRST, 5, 16'hFFFF);
        push_req(CMD_LOAD, POL_FIRST, 9, 16'hFFFF);
        push_req(CMD_ALLOC, POL_WORST, 0, 16'hFFFF);
        push_req(CMD_ALLOC, POL_WORST, 0, 16'hFFFF);
        push_req(CMD_LOAD, POL_FIRST, 3, 16'd0);
        push_req(CMD_LOAD, POL_FIRST, 7, 16'd0);
        push_req(CMD_ALLOC, POL_BEST, 0, 16'd0);
        push_req(CMD_ALLOC, POL_BEST, 0, 16'd0);
        push_req(CMD_LOAD, POL_FIRST, 62, 16'hFFFF);
        push_req(CMD_ALLOC, POL_NEXT, 0, 16'hFFFF);
        push_req(CMD_ALLOC, POL_FIRST, 0, 16'd0);

        // rover past the active range
        write_count(7'd8);
        push_req(CMD_ALLOC, POL_NEXT, 0, 16'd0);
        push_req(CMD_ALLOC, POL_NEXT, 0, 16'd0);

        // counts above the table size
        write_count(7'd100);
        push_req(CMD_ALLOC, POL_WORST, 0, 16'd0);
        write_count(7'd127);
        push_req(CMD_ALLOC, POL_FIRST, 0, 16'd0);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0, 3: cnt = 7'd64;
                1: cnt = 7'd1;
                2: cnt = 7'd0;
                5: cnt = 7'd127;
                default: cnt = ($urandom_range(0, 4) == 0) ? PIN_W'($urandom_range(65, 127))
                                                           : PIN_W'($urandom_range(1, 64));
            endcase
            write_count(cnt);
            idle_enable = (ph % 3 != 1);
            if (ph == 3) stall_asks++;
            for (k = 0; k < PHASE_ITEMS; k++)
                pending_reqs.push_back(random_req());
            pushed_total += PHASE_ITEMS;
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (expected_grants.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_grants.size());
            errors++;
        end
        $display("covered %0d load and %0d allocate requests, %0d granted, %0d count writes",
                 loads_sent, allocs_sent, grants_seen, count_writes);
        $display("all four fit policies, zero and oversized counts, rover wrap, %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
